FILE: rtl/rilp_pkg.sv
// Shared types, constants and the character decode for the radix integer literal parser.
`default_nettype none
package rilp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned NumW    = 64;
  localparam int unsigned BaseW   = 6;
  localparam int unsigned DigitW  = 7;
  localparam int unsigned ProdW   = NumW + BaseW;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [CharW-1:0] ChMinus = 8'h2D;  // '-'
  localparam logic [CharW-1:0] ChHash  = 8'h23;  // '#'
  localparam logic [CharW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChLowX  = 8'h78;  // 'x'
  localparam logic [CharW-1:0] ChUpX   = 8'h58;  // 'X'

  localparam logic [BaseW-1:0] BaseOct = 6'd8;
  localparam logic [BaseW-1:0] BaseDec = 6'd10;
  localparam logic [BaseW-1:0] BaseHex = 6'd16;
  localparam logic [BaseW-1:0] BaseMin = 6'd2;
  localparam logic [BaseW-1:0] BaseMax = 6'd36;

  // marks a character that is no digit in any base
  localparam logic [DigitW-1:0] DigitBad = 7'd127;

  // largest magnitude the accumulator may reach (that of the most negative value)
  localparam logic [ProdW-1:0] MagLimit = ProdW'(64'h8000_0000_0000_0000);

  // register index, taken from paddr[2]
  localparam logic RegPrefixMode = 1'b0;
  localparam logic RegRadix      = 1'b1;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_DSIGN  = 4'b0010,
    PH_DZERO  = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NODIGITS = 2'd1,
    ST_INVALID  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic            invalid;
    logic            overflow;
    logic [NumW-1:0] acc;
  } digit_res_t;

  function automatic logic [DigitW-1:0] char_value(input logic [CharW-1:0] c);
    logic [DigitW-1:0] v;
    v = DigitBad;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = DigitW'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = DigitW'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      v = DigitW'(c - 8'h41 + 8'd10);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rilp_in_if.sv
// Character stream channel: one character item with its end-of-number flag.
`default_nettype none
interface rilp_in_if;
  import rilp_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface
`default_nettype wire

FILE: rtl/rilp_out_if.sv
// Result channel: parsed value and status.
`default_nettype none
interface rilp_out_if;
  import rilp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [NumW-1:0] number;
  logic [1:0]             status;

  modport source (output valid, number, status, input ready);
  modport sink   (input valid, number, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/rilp_digit.sv
// One digit step: decode, multiply-add into the magnitude and range check.
`default_nettype none
module rilp_digit (
  input  logic [rilp_pkg::NumW-1:0]  acc_i,
  input  logic [rilp_pkg::BaseW-1:0] base_i,
  input  logic [rilp_pkg::CharW-1:0] char_i,
  output rilp_pkg::digit_res_t       res_o
);
  import rilp_pkg::*;

  logic [DigitW-1:0] digit;
  logic [ProdW-1:0]  prod;
  logic [ProdW-1:0]  sum;

  assign digit = char_value(char_i);
  assign prod  = ProdW'(acc_i) * ProdW'(base_i);
  assign sum   = prod + ProdW'(digit);

  // acc*base + d > 2^63 is the same test as acc > (2^63 - d) / base
  assign res_o.invalid  = digit >= DigitW'(base_i);
  assign res_o.overflow = sum > MagLimit;
  assign res_o.acc      = sum[NumW-1:0];

endmodule
`default_nettype wire

FILE: rtl/radix_integer_literal_parser_unit.sv
// Radix integer literal parser: top level with config registers and parse state.
// Pipeline: a character item is taken into the input register and parsed from there;
//   a result is written to the result register when its last character is parsed.
// Throughput: one character per cycle while no last character waits on a full result slot.
// Reset: config returns to plain mode, radix ten; parse state to start of number.
`default_nettype none
module radix_integer_literal_parser_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rilp_in_if.sink                    in_i,
  rilp_out_if.source                 out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rilp_pkg::AddrW-1:0] paddr,
  input  logic [rilp_pkg::DataW-1:0] pwdata,
  output logic [rilp_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import rilp_pkg::*;

  // configuration
  logic             mode_q;
  logic [BaseW-1:0] radix_q;
  logic             cfg_wr;

  // input register
  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;

  // parse state
  logic [NumW-1:0]  acc_q, acc_d;
  logic             neg_q, neg_d;
  phase_e           phase_q, phase_d;
  logic [BaseW-1:0] base_q, base_d;
  logic             seen_q, seen_d;
  status_e          err_q, err_d;

  // result register
  logic             out_valid_q;
  logic [NumW-1:0]  out_mag_q;
  logic             out_neg_q;
  status_e          out_status_q;

  logic             out_free;
  logic             proc_fire;
  logic [BaseW-1:0] radix_clamped;
  logic [BaseW-1:0] dig_base;
  digit_res_t       dig;
  status_e          res_status;
  logic [NumW-1:0]  res_mag;

  // APB port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      RegPrefixMode: prdata = DataW'(mode_q);
      RegRadix:      prdata = DataW'(radix_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      radix_q <= BaseDec;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegPrefixMode: mode_q  <= pwdata[0];
        RegRadix:      radix_q <= pwdata[BaseW-1:0];
        default:       mode_q  <= mode_q;
      endcase
    end
  end

  // handshake: a character moves on unless it ends a number and the result slot is full
  assign out_free  = !out_valid_q || out_o.ready;
  assign proc_fire = in_valid_q && (!in_last_q || out_free);
  assign in_i.ready = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_char_q <= in_i.char_code;
      in_last_q <= in_i.last_char;
    end
  end

  always_comb begin
    if (radix_q < BaseMin) begin
      radix_clamped = BaseMin;
    end else if (radix_q > BaseMax) begin
      radix_clamped = BaseMax;
    end else begin
      radix_clamped = radix_q;
    end
  end

  // base for a digit taken in this cycle; an unprefixed first digit in decode mode is decimal
  always_comb begin
    if (phase_q == PH_START && !mode_q) begin
      dig_base = radix_clamped;
    end else if (phase_q == PH_START || phase_q == PH_DSIGN) begin
      dig_base = BaseDec;
    end else begin
      dig_base = base_q;
    end
  end

  rilp_digit u_digit (
    .acc_i  (acc_q),
    .base_i (dig_base),
    .char_i (in_char_q),
    .res_o  (dig)
  );

  always_comb begin
    logic take_dig;
    logic lead;
    take_dig = 1'b0;
    lead     = 1'b0;
    acc_d    = acc_q;
    neg_d    = neg_q;
    phase_d  = phase_q;
    base_d   = base_q;
    seen_d   = seen_q;
    err_d    = err_q;

    if (err_q == ST_OK) begin
      case (phase_q)
        PH_START: begin
          if (mode_q) begin
            if (in_char_q == ChMinus) begin
              neg_d   = 1'b1;
              phase_d = PH_DSIGN;
            end else begin
              lead = 1'b1;
            end
          end else begin
            base_d  = radix_clamped;
            phase_d = PH_DIGITS;
            if (in_char_q == ChMinus) begin
              neg_d = 1'b1;
            end else begin
              take_dig = 1'b1;
            end
          end
        end
        PH_DSIGN: lead = 1'b1;
        PH_DZERO: begin
          phase_d = PH_DIGITS;
          if (in_char_q == ChLowX || in_char_q == ChUpX) begin
            base_d = BaseHex;
            seen_d = 1'b0;
          end else begin
            take_dig = 1'b1;
          end
        end
        PH_DIGITS: take_dig = 1'b1;
        default:   phase_d = PH_START;
      endcase

      if (lead) begin
        if (in_char_q == ChZero) begin
          base_d  = BaseOct;
          seen_d  = 1'b1;
          phase_d = PH_DZERO;
        end else if (in_char_q == ChHash) begin
          base_d  = BaseHex;
          phase_d = PH_DIGITS;
        end else begin
          base_d   = BaseDec;
          phase_d  = PH_DIGITS;
          take_dig = 1'b1;
        end
      end

      if (take_dig) begin
        if (dig.invalid) begin
          err_d = ST_INVALID;
        end else if (dig.overflow) begin
          err_d = ST_OVERFLOW;
        end else begin
          acc_d  = dig.acc;
          seen_d = 1'b1;
        end
      end
    end
  end

  // final status; the sign itself is applied on the output side
  always_comb begin
    res_status = err_d;
    if (res_status == ST_OK && !seen_d) begin
      res_status = ST_NODIGITS;
    end else if (res_status == ST_OK && !neg_d && acc_d[NumW-1]) begin
      res_status = ST_OVERFLOW;
    end
    res_mag = (res_status == ST_OK) ? acc_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      neg_q   <= 1'b0;
      phase_q <= PH_START;
      base_q  <= BaseDec;
      seen_q  <= 1'b0;
      err_q   <= ST_OK;
    end else if (proc_fire) begin
      if (in_last_q) begin
        acc_q   <= '0;
        neg_q   <= 1'b0;
        phase_q <= PH_START;
        base_q  <= BaseDec;
        seen_q  <= 1'b0;
        err_q   <= ST_OK;
      end else begin
        acc_q   <= acc_d;
        neg_q   <= neg_d;
        phase_q <= phase_d;
        base_q  <= base_d;
        seen_q  <= seen_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && in_last_q) begin
      out_mag_q    <= res_mag;
      out_neg_q    <= neg_d;
      out_status_q <= res_status;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.number = out_neg_q ? $signed(NumW'(0) - out_mag_q) : $signed(out_mag_q);

  // a failed parse carries no magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != ST_OK |-> out_mag_q == '0)
    else $error("non-zero magnitude with an error status");

  // the first error stays until the number ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && !in_last_q && err_q != ST_OK |=> err_q == $past(err_q))
    else $error("error code changed in mid-number");

  // the end of a number leaves a clean state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && in_last_q |=> phase_q == PH_START && err_q == ST_OK && !seen_q)
    else $error("parse state not cleared after a number");

  // a leading zero in decode mode means octal with a digit already seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DZERO |-> base_q == BaseOct && seen_q)
    else $error("octal lead state inconsistent");

  // the magnitude never passes 2^63
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q[NumW-1] |-> acc_q[NumW-2:0] == '0)
    else $error("accumulator beyond the signed range");

endmodule
`default_nettype wire

FILE: sim/radix_integer_literal_parser_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the radix integer literal parser: text items, APB config, scoreboard.
module radix_integer_literal_parser_unit_tb;
  import rilp_pkg::*;

  localparam logic [63:0] MagTop       = 64'h8000_0000_0000_0000;
  localparam logic [7:0]  ChLowA       = 8'h61;
  localparam logic [7:0]  ChUpA        = 8'h41;
  localparam logic [6:0]  NoDigit      = 7'd127;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseItems   = 400;
  localparam int unsigned SegItems     = 80;

  typedef struct {
    logic [63:0] number;
    status_e     status;
  } parse_res_t;

  // Tracks one number in flight and queues the value/status each last char should give.
  class parse_tracker;
    bit          mode;
    logic [5:0]  radix_reg;
    phase_e      ph;
    logic [5:0]  base;
    logic [63:0] mag;
    bit          neg;
    bit          seen;
    status_e     err;
    parse_res_t  expected_q[$];
    int unsigned fails;

    function new();
      mode      = 1'b0;
      radix_reg = BaseDec;
      fails     = 0;
      clear();
    endfunction

    function void clear();
      mag  = '0;
      neg  = 1'b0;
      ph   = PH_START;
      base = BaseDec;
      seen = 1'b0;
      err  = ST_OK;
    endfunction

    function void set_reg(logic idx, logic [5:0] v);
      if (idx == RegPrefixMode) mode = v[0];
      else radix_reg = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic [5:0] plain_base();
      if (radix_reg < BaseMin) return BaseMin;
      if (radix_reg > BaseMax) return BaseMax;
      return radix_reg;
    endfunction

    function logic [6:0] digit_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30);
      if (c >= ChLowA && c <= 8'h7A) return 7'(c - ChLowA + 8'd10);
      if (c >= ChUpA && c <= 8'h5A) return 7'(c - ChUpA + 8'd10);
      return NoDigit;
    endfunction

    function void take_digit(logic [7:0] c);
      logic [63:0] d;
      logic [63:0] b;
      d = 64'(digit_of(c));
      b = 64'(base);
      if (d >= b) begin
        err = ST_INVALID;
        return;
      end
      if (mag > (MagTop - d) / b) begin
        err = ST_OVERFLOW;
        return;
      end
      mag  = mag * b + d;
      seen = 1'b1;
    endfunction

    // first char after an optional sign in decode mode
    function void take_lead(logic [7:0] c);
      if (c == ChZero) begin
        base = BaseOct;
        seen = 1'b1;
        ph   = PH_DZERO;
      end else if (c == ChHash) begin
        base = BaseHex;
        ph   = PH_DIGITS;
      end else begin
        base = BaseDec;
        ph   = PH_DIGITS;
        take_digit(c);
      end
    endfunction

    function void note_char(logic [7:0] c, logic is_last);
      parse_res_t r;
      if (err == ST_OK) begin
        case (ph)
          PH_START: begin
            if (mode) begin
              if (c == ChMinus) begin
                neg = 1'b1;
                ph  = PH_DSIGN;
              end else begin
                take_lead(c);
              end
            end else begin
              base = plain_base();
              ph   = PH_DIGITS;
              if (c == ChMinus) neg = 1'b1;
              else take_digit(c);
            end
          end
          PH_DSIGN: take_lead(c);
          PH_DZERO: begin
            ph = PH_DIGITS;
            if (c == ChLowX || c == ChUpX) begin
              base = BaseHex;
              seen = 1'b0;
            end else begin
              take_digit(c);
            end
          end
          default: take_digit(c);
        endcase
      end
      if (!is_last) return;
      r.number = '0;
      r.status = err;
      if (r.status == ST_OK && !seen) r.status = ST_NODIGITS;
      if (r.status == ST_OK) begin
        if (neg) r.number = -mag;
        else if (mag >= MagTop) r.status = ST_OVERFLOW;
        else r.number = mag;
      end
      expected_q.push_back(r);
      clear();
    endfunction

    function void check_result(logic [63:0] num, logic [1:0] st);
      parse_res_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: number %0d status %0d", $signed(num), st);
        fails++;
        return;
      end
      e = expected_q.pop_front();
      if (num !== e.number) begin
        $error("number: expected %0d, got %0d", $signed(e.number), $signed(num));
        fails++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        fails++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  rilp_in_if  char_if ();
  rilp_out_if res_if ();

  radix_integer_literal_parser_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (char_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  parse_tracker tracker = new();
  logic [7:0]   text_q[$];
  int unsigned  chars_sent;
  int unsigned  src_idle_pct;
  int unsigned  sink_idle_pct;
  int unsigned  hold_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side: long hold-off when asked, else random stalls
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      res_if.ready = 1'b0;
      hold_left    = hold_left - 1;
    end else begin
      res_if.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) tracker.check_result(res_if.number, res_if.status);
    if (char_if.valid && char_if.ready) tracker.note_char(char_if.char_code, char_if.last_char);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((char_if.valid && char_if.ready) || (res_if.valid && res_if.ready) || psel) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_char(input logic [7:0] c, input logic is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      char_if.valid = 1'b0;
      @(negedge clk_i);
    end
    char_if.valid     = 1'b1;
    char_if.char_code = c;
    char_if.last_char = is_last;
    do @(posedge clk_i); while (!char_if.ready);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_str(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  // sender pauses until every pending result is out, plus settling time
  task automatic drain();
    char_if.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic idx, input logic [5:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = $urandom;
    if (idx == RegPrefixMode) pwdata[0] = v[0];
    else pwdata[5:0] = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_reg(idx, v);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(input bit m, input logic [5:0] r);
    drain();
    apb_write(RegPrefixMode, {5'b0, m});
    apb_write(RegRadix, r);
  endtask

  function automatic logic [5:0] pick_radix();
    if ($urandom_range(2) != 0) return 6'($urandom_range(BaseMin, BaseMax));
    case ($urandom_range(5))
      0:       return 6'd0;
      1:       return 6'd1;
      2:       return BaseMin;
      3:       return BaseMax;
      4:       return 6'd37;
      default: return 6'd63;
    endcase
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) return 8'(8'h30 + d);
    return 8'(($urandom_range(1) ? ChLowA : ChUpA) + d - 10);
  endfunction

  task automatic push_value(input logic [63:0] v, input logic [5:0] b);
    logic [7:0] tmp[$];
    do begin
      tmp.push_front(digit_char(int'(v % b)));
      v = v / b;
    end while (v != 0);
    foreach (tmp[i]) text_q.push_back(tmp[i]);
  endtask

  // mostly well-formed numbers in the live base, plus limits, bare prefixes and junk
  task automatic build_number();
    int unsigned kind;
    int unsigned n;
    logic [5:0]  b;
    logic [63:0] v;
    text_q.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      n = $urandom_range(1, 4);
      repeat (n) text_q.push_back(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(3) == 0) text_q.push_back(ChMinus);
    b = tracker.plain_base();
    if (tracker.mode) begin
      case ($urandom_range(3))
        0: b = BaseDec;
        1: begin
          text_q.push_back(ChZero);
          text_q.push_back($urandom_range(1) ? ChLowX : ChUpX);
          b = BaseHex;
        end
        2: begin
          text_q.push_back(ChHash);
          b = BaseHex;
        end
        default: begin
          text_q.push_back(ChZero);
          b = BaseOct;
        end
      endcase
    end
    if (kind < 20) begin
      if (text_q.size() == 0) text_q.push_back(ChMinus);
      return;
    end
    if (kind < 36) begin
      case ($urandom_range(4))
        0:       v = MagTop - 1;
        1:       v = MagTop;
        2:       v = MagTop + 1;
        3:       v = '1;
        default: v = {$urandom, $urandom};
      endcase
      push_value(v, b);
      if ($urandom_range(3) == 0) text_q.push_back(digit_char($urandom_range(b - 1)));
      return;
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    repeat (n) text_q.push_back(digit_char($urandom_range(b - 1)));
    if (kind >= 90)
      text_q.insert($urandom_range(text_q.size()),
                    $urandom_range(1) ? ChMinus : 8'($urandom_range(255)));
  endtask

  initial begin : stimulus
    int unsigned seg_end;
    rst_ni            = 1'b0;
    char_if.valid     = 1'b0;
    char_if.char_code = '0;
    char_if.last_char = 1'b0;
    res_if.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    chars_sent        = 0;
    hold_left         = 0;
    src_idle_pct      = 34;
    sink_idle_pct     = 81;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // decode mode: bare signs and prefixes, lone zero, sign after prefix
    configure(1'b1, BaseDec);
    send_str("-");
    send_str("#");
    send_str("0x");
    send_str("-#");
    send_str("-0X");
    send_str("0");
    send_str("-0");
    send_str("0-");
    send_str("--");
    send_str("#fF");
    // plain mode at the top radix, plus the extreme char codes
    configure(1'b0, BaseMax);
    send_str("zZ");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);

    for (int p = 0; p < 3; p++) begin
      src_idle_pct  = (p == 0) ? 34 : (p == 1) ? 81 : 0;
      sink_idle_pct = (p == 0) ? 81 : (p == 1) ? 34 : 0;
      if (p == 2) begin
        // back-pressure: results held off while short numbers keep coming
        configure(1'($urandom_range(1)), pick_radix());
        hold_left = 300;
        repeat (60) begin
          text_q.delete();
          text_q.push_back(digit_char($urandom_range(tracker.plain_base() - 1)));
          send_text();
        end
      end
      while (chars_sent < (p + 1) * PhaseItems) begin
        configure(1'($urandom_range(1)), pick_radix());
        seg_end = chars_sent + SegItems;
        while (chars_sent < seg_end) begin
          build_number();
          send_text();
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (tracker.fails == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: radix_integer_literal_parser_unit.f
rtl/rilp_pkg.sv
rtl/rilp_in_if.sv
rtl/rilp_out_if.sv
rtl/rilp_digit.sv
rtl/radix_integer_literal_parser_unit.sv
sim/radix_integer_literal_parser_unit_tb.sv
